// ===== rtl/core/bdmlc_pkg.sv =====
// Shared types and constants of the button debounce and mode LED block.
package bdmlc_pkg;

	localparam int SETTLE_W = 8;
	localparam int BLINK_W  = 16;
	localparam int MODE_W   = 4;
	localparam int CFG_W    = 16;

	// Configuration register indexes
	localparam logic CFG_SETTLE = 1'b0;
	localparam logic CFG_BLINK  = 1'b1;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_OFF      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_A_RX     = 4'd1;
	localparam logic [MODE_W-1:0] MODE_A_TX     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_A_SCAN   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_B_RX     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_B_TX     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_B_SCAN   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SNIFF_A  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SNIFF_B  = 4'd8;
	localparam logic [MODE_W:0]   MODE_COUNT    = 5'd9;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd10;
	localparam logic [BLINK_W-1:0]  BLINK_RESET  = 16'd250;

	// LED drive and mode after one tick
	typedef struct packed {
		logic              second_led_on;
		logic              first_led_on;
		logic [MODE_W-1:0] mode_now;
	} lamp_t;

endpackage

// ===== rtl/core/bdmlc_debounce.sv =====
// Debouncer for one button: debounced level and last mismatch stamp.
module bdmlc_debounce #(
	parameter int STAMP_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          raw,
	input  logic [STAMP_WIDTH-1:0]        tick_next,
	input  logic [bdmlc_pkg::SETTLE_W-1:0] settle,
	output logic                          clean_next
);

	logic                   clean_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	logic [STAMP_WIDTH-1:0] elapsed;
	logic                   mismatch;

	assign mismatch   = raw != clean_q;
	assign elapsed    = tick_next - stamp_q;
	assign clean_next = (mismatch && (elapsed > STAMP_WIDTH'(settle))) ? raw : clean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clean_q <= 1'b0;
			stamp_q <= '0;
		end else if (advance) begin
			clean_q <= clean_next;
			// restamp on every mismatch, taken over or not
			if (mismatch) begin
				stamp_q <= tick_next;
			end
		end
	end

endmodule

// ===== rtl/core/bdmlc_mode_led.sv =====
// Blink counter, mode stepper and LED pattern logic.
module bdmlc_mode_led (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          press_level,
	input  logic [bdmlc_pkg::BLINK_W-1:0] blink_ticks,
	output bdmlc_pkg::lamp_t              lamp_next
);

	logic [bdmlc_pkg::BLINK_W-1:0] blink_cnt_q;
	logic [bdmlc_pkg::BLINK_W-1:0] cnt_inc;
	logic [bdmlc_pkg::MODE_W-1:0]  mode_q;
	logic [bdmlc_pkg::MODE_W:0]    mode_inc;
	logic                          led1_q;
	logic                          led2_q;
	logic                          prev_q;
	logic                          hit;
	logic                          led1_d;
	logic                          led2_d;
	logic [bdmlc_pkg::MODE_W-1:0]  mode_d;

	assign cnt_inc  = blink_cnt_q + 1'b1;
	assign hit      = cnt_inc >= blink_ticks;
	assign mode_inc = {1'b0, mode_q} + 1'b1;

	always_comb begin
		led1_d = led1_q;
		led2_d = led2_q;
		case (mode_q) inside
			bdmlc_pkg::MODE_OFF: begin
				led1_d = 1'b0;
				led2_d = 1'b0;
			end
			bdmlc_pkg::MODE_A_RX, bdmlc_pkg::MODE_A_SCAN, bdmlc_pkg::MODE_SNIFF_A: begin
				led1_d = led1_q ^ hit;
				led2_d = 1'b0;
			end
			bdmlc_pkg::MODE_A_TX: begin
				led1_d = 1'b1;
				led2_d = 1'b0;
			end
			bdmlc_pkg::MODE_B_RX, bdmlc_pkg::MODE_B_SCAN, bdmlc_pkg::MODE_SNIFF_B: begin
				led1_d = 1'b0;
				led2_d = led2_q ^ hit;
			end
			bdmlc_pkg::MODE_B_TX: begin
				led1_d = 1'b0;
				led2_d = 1'b1;
			end
			default: begin
				// hold levels for codes that cannot arise
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		if (press_level && !prev_q) begin
			if (mode_inc >= bdmlc_pkg::MODE_COUNT) begin
				mode_d = bdmlc_pkg::MODE_W'(mode_inc - bdmlc_pkg::MODE_COUNT);
			end else begin
				mode_d = mode_inc[bdmlc_pkg::MODE_W-1:0];
			end
		end
	end

	assign lamp_next.first_led_on  = led1_d;
	assign lamp_next.second_led_on = led2_d;
	assign lamp_next.mode_now      = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_cnt_q <= '0;
			mode_q      <= bdmlc_pkg::MODE_OFF;
			led1_q      <= 1'b0;
			led2_q      <= 1'b0;
			prev_q      <= 1'b0;
		end else if (advance) begin
			blink_cnt_q <= hit ? '0 : cnt_inc;
			mode_q      <= mode_d;
			led1_q      <= led1_d;
			led2_q      <= led2_d;
			prev_q      <= press_level;
		end
	end

endmodule

// ===== rtl/core/button_debounce_mode_led_control_unit.sv =====
// Top level: two-button debouncer driving a nine-way mode selector and two LEDs.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: first, second raw button level
//  m_*      out  m_tvalid/m_tready  m_tdata: LEDs, mode, debounced levels
//  cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// One request per clock sustained while the output is taken; a request passes through the input
// register, then one pass of debounce, blink and mode logic into the output register,
// where its result is held until taken. The output register frees itself in the same
// cycle it is taken, so the input side stalls only while the output waits and the input
// register is full.
// Reset clears all tick, debounce, blink, mode and LED state and loads the register
// defaults (settle 10, blink 250); no clearing pass is needed.
module button_debounce_mode_led_control_unit #(
	parameter int STAMP_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] first_button_pressed, [1] second_button_pressed, [7:2] zero
	input  logic [7:0]                    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] first_led_on, [1] second_led_on, [5:2] mode_now,
	// [6] first_button_clean, [7] second_button_clean
	output logic [7:0]                    m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bdmlc_pkg::CFG_W-1:0]   cfg_wdata
);

	logic                            valid_s1;
	logic [1:0]                      raw_s1;
	logic                            advance;
	logic [bdmlc_pkg::SETTLE_W-1:0]  settle_q;
	logic [bdmlc_pkg::BLINK_W-1:0]   blink_q;
	logic [STAMP_WIDTH-1:0]          tick_q;
	logic [STAMP_WIDTH-1:0]          tick_next;
	logic                            clean1_next;
	logic                            clean2_next;
	bdmlc_pkg::lamp_t                lamp_next;
	logic                            out_valid_q;
	logic [7:0]                      out_data_q;

	// advance the held request once the output register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign tick_next = tick_q + 1'b1;

	// configuration decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= bdmlc_pkg::SETTLE_RESET;
			blink_q  <= bdmlc_pkg::BLINK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdmlc_pkg::CFG_SETTLE: settle_q <= cfg_wdata[bdmlc_pkg::SETTLE_W-1:0];
				bdmlc_pkg::CFG_BLINK:  blink_q  <= cfg_wdata[bdmlc_pkg::BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata[1:0];
		end
	end

	// tick stamp, stepped first on every tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (advance) begin
			tick_q <= tick_next;
		end
	end

	bdmlc_debounce #(
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_deb_first (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.raw        (raw_s1[0]),
		.tick_next  (tick_next),
		.settle     (settle_q),
		.clean_next (clean1_next)
	);

	bdmlc_debounce #(
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_deb_second (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.raw        (raw_s1[1]),
		.tick_next  (tick_next),
		.settle     (settle_q),
		.clean_next (clean2_next)
	);

	// LED pattern uses the mode before this tick; a fresh press of button one steps it
	bdmlc_mode_led u_mode_led (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.press_level (clean1_next),
		.blink_ticks (blink_q),
		.lamp_next   (lamp_next)
	);

	// output register: hold until taken, refill in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {clean2_next, clean1_next, lamp_next.mode_now,
				lamp_next.second_led_on, lamp_next.first_led_on};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// mode never leaves its nine codes
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:2] <= bdmlc_pkg::MODE_SNIFF_B))
		else $error("mode out of range");

	// hold the result unchanged while the receiver stalls
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// never both LEDs lit at once
	a_one_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("both LEDs lit");

	// an empty output register never stalls the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule
